/* hdl/eirc_pkg.sv */
// eirc_pkg: shared types and constants of the ethernet ipv4 receive classifier
// used by eirc_front, eirc_sumq, eirc_back and eth_ipv4_rx_classifier
// no dependencies
package eirc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 16384;
  localparam int POS_W               = 15;
  localparam int POS_CAP             = 32767;
  localparam int SUMQ_DEPTH          = 2;

  localparam logic [POS_W-1:0] ETH_HDR_BYTES = 15'd14;
  localparam logic [POS_W-1:0] L3_END_BYTES  = 15'd34;
  localparam logic [15:0]      TYPE_ARP      = 16'h0806;
  localparam logic [15:0]      TYPE_IPV4     = 16'h0800;
  localparam logic [7:0]       PROTO_ICMP    = 8'd1;
  localparam logic [7:0]       PROTO_TCP     = 8'd6;
  localparam logic [7:0]       PROTO_UDP     = 8'd17;
  localparam logic [15:0]      IP_HDR_BYTES  = 16'd20;
  localparam logic [15:0]      FLAG_MF       = 16'h2000;

  typedef enum logic [1:0] {
    V_DELIVER = 2'd0,
    V_ICMP    = 2'd1,
    V_ARP     = 2'd2,
    V_DROP    = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    R_NONE      = 3'd0,
    R_SHORT_L2  = 3'd1,
    R_MISMATCH  = 3'd2,
    R_SHORT_L3  = 3'd3,
    R_CHECKSUM  = 3'd4,
    R_UNSUPP    = 3'd5,
    R_TRUNCATED = 3'd6,
    R_PROTOCOL  = 3'd7
  } reason_t;

  // everything the back end needs about one finished frame
  typedef struct packed {
    logic [POS_W-1:0] frame_len;
    logic             mac_match;
    logic [15:0]      ether_type;
    logic [7:0]       version_ihl;
    logic [15:0]      total_length;
    logic [15:0]      flags_fragment;
    logic [7:0]       ip_protocol;
    logic [19:0]      csum_accum;
    logic             csum_skip;
  } frame_sum_t;

endpackage

/* hdl/eirc_front.sv */
// eirc_front: byte parser, tracks position and captures header fields per frame
// emits one frame summary at the last byte
// depends on eirc_pkg
module eirc_front import eirc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  input  logic        csum_preverified,
  input  logic [47:0] station_mac,
  output logic        sum_push,
  output frame_sum_t  sum_data
);

  localparam int POS_LIMIT_I = (MAX_FRAME_BYTES < POS_CAP) ? MAX_FRAME_BYTES : POS_CAP;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             mac_match_r, mac_match_nxt;
  logic [15:0]      ether_type_r, ether_type_nxt;
  logic [7:0]       version_ihl_r, version_ihl_nxt;
  logic [15:0]      total_length_r, total_length_nxt;
  logic [15:0]      flags_r, flags_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [19:0]      accum_r, accum_nxt;
  logic             skip_r, skip_nxt;

  logic [POS_W-1:0] off;
  logic [7:0]       want;
  frame_sum_t       abs_s;

  assign off = pos_r - ETH_HDR_BYTES;

  always_comb begin
    case (pos_r[2:0])
      3'd0:    want = station_mac[47:40];
      3'd1:    want = station_mac[39:32];
      3'd2:    want = station_mac[31:24];
      3'd3:    want = station_mac[23:16];
      3'd4:    want = station_mac[15:8];
      default: want = station_mac[7:0];
    endcase
  end

  // absorb the current byte into the frame state
  always_comb begin
    abs_s.frame_len      = pos_r;
    abs_s.mac_match      = mac_match_r;
    abs_s.ether_type     = ether_type_r;
    abs_s.version_ihl    = version_ihl_r;
    abs_s.total_length   = total_length_r;
    abs_s.flags_fragment = flags_r;
    abs_s.ip_protocol    = proto_r;
    abs_s.csum_accum     = accum_r;
    abs_s.csum_skip      = skip_r;
    if (byte_valid && (pos_r < POS_LIMIT)) begin
      abs_s.frame_len = pos_r + 1'b1;
      if (pos_r == '0) begin
        abs_s.csum_skip = csum_preverified;
      end
      if (pos_r < POS_W'(6)) begin
        if (want != frame_byte) begin
          abs_s.mac_match = 1'b0;
        end
      end else if (pos_r == POS_W'(12)) begin
        abs_s.ether_type[15:8] = frame_byte;
      end else if (pos_r == POS_W'(13)) begin
        abs_s.ether_type[7:0] = frame_byte;
      end
      if ((pos_r >= ETH_HDR_BYTES) && (pos_r < L3_END_BYTES)) begin
        // header words are big endian: even offsets carry the high byte
        abs_s.csum_accum = accum_r + (off[0] ? {12'd0, frame_byte} : {4'd0, frame_byte, 8'd0});
        case (off[4:0])
          5'd0:    abs_s.version_ihl = frame_byte;
          5'd2:    abs_s.total_length[15:8] = frame_byte;
          5'd3:    abs_s.total_length[7:0] = frame_byte;
          5'd6:    abs_s.flags_fragment[15:8] = frame_byte;
          5'd7:    abs_s.flags_fragment[7:0] = frame_byte;
          5'd9:    abs_s.ip_protocol = frame_byte;
          default: ;
        endcase
      end
    end
  end

  assign sum_push = byte_valid && last_byte;
  assign sum_data = abs_s;

  always_comb begin
    if (sum_push) begin
      pos_nxt          = '0;
      mac_match_nxt    = 1'b1;
      ether_type_nxt   = '0;
      version_ihl_nxt  = '0;
      total_length_nxt = '0;
      flags_nxt        = '0;
      proto_nxt        = '0;
      accum_nxt        = '0;
      skip_nxt         = 1'b0;
    end else begin
      pos_nxt          = abs_s.frame_len;
      mac_match_nxt    = abs_s.mac_match;
      ether_type_nxt   = abs_s.ether_type;
      version_ihl_nxt  = abs_s.version_ihl;
      total_length_nxt = abs_s.total_length;
      flags_nxt        = abs_s.flags_fragment;
      proto_nxt        = abs_s.ip_protocol;
      accum_nxt        = abs_s.csum_accum;
      skip_nxt         = abs_s.csum_skip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= '0;
      mac_match_r    <= 1'b1;
      ether_type_r   <= '0;
      version_ihl_r  <= '0;
      total_length_r <= '0;
      flags_r        <= '0;
      proto_r        <= '0;
      accum_r        <= '0;
      skip_r         <= 1'b0;
    end else begin
      pos_r          <= pos_nxt;
      mac_match_r    <= mac_match_nxt;
      ether_type_r   <= ether_type_nxt;
      version_ihl_r  <= version_ihl_nxt;
      total_length_r <= total_length_nxt;
      flags_r        <= flags_nxt;
      proto_r        <= proto_nxt;
      accum_r        <= accum_nxt;
      skip_r         <= skip_nxt;
    end
  end

  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT) else $error("byte position past limit");

endmodule

/* hdl/eirc_sumq.sv */
// eirc_sumq: short queue of frame summaries between front and back end
// depends on eirc_pkg
module eirc_sumq import eirc_pkg::*; #(
  parameter int DEPTH = SUMQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_sum_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output frame_sum_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_sum_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("summary queue overfilled");

endmodule

/* hdl/eirc_back.sv */
// eirc_back: turns a frame summary into a verdict and holds it in the output register
// depends on eirc_pkg
module eirc_back import eirc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        sum_valid,
  input  frame_sum_t  sum_data,
  output logic        sum_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_verdict,
  output logic [2:0]  out_drop_reason,
  output logic [7:0]  out_protocol,
  output logic [15:0] out_l4_length
);

  logic             out_valid_r, out_valid_nxt;
  verdict_t         verdict_r, verdict_c;
  reason_t          reason_r, reason_c;
  logic [7:0]       proto_r, proto_c;
  logic [15:0]      l4_r, l4_c;

  logic             has_l3;
  logic [16:0]      fold1;
  logic [16:0]      fold2;
  logic [POS_W-1:0] payload_len;
  logic             load;

  assign has_l3      = (sum_data.frame_len >= L3_END_BYTES) && (sum_data.ether_type != TYPE_ARP);
  assign fold1       = {1'b0, sum_data.csum_accum[15:0]} + {13'd0, sum_data.csum_accum[19:16]};
  assign fold2       = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
  assign payload_len = sum_data.frame_len - L3_END_BYTES;

  always_comb begin
    proto_c   = has_l3 ? sum_data.ip_protocol : 8'd0;
    l4_c      = has_l3 ? (sum_data.total_length - IP_HDR_BYTES) : 16'd0;
    verdict_c = V_DROP;
    reason_c  = R_NONE;
    if (sum_data.frame_len < ETH_HDR_BYTES) begin
      reason_c = R_SHORT_L2;
    end else if (sum_data.ether_type == TYPE_ARP) begin
      verdict_c = V_ARP;
    end else if ((sum_data.ether_type != TYPE_IPV4) || !sum_data.mac_match) begin
      reason_c = R_MISMATCH;
    end else if (sum_data.frame_len < L3_END_BYTES) begin
      reason_c = R_SHORT_L3;
    end else if (!sum_data.csum_skip && (fold2[15:0] != 16'hFFFF)) begin
      reason_c = R_CHECKSUM;
    end else if ((sum_data.version_ihl != 8'h45) ||
                 ((sum_data.flags_fragment & FLAG_MF) != 16'd0)) begin
      reason_c = R_UNSUPP;
    end else if ({1'b0, payload_len} < l4_c) begin
      reason_c = R_TRUNCATED;
    end else if (sum_data.ip_protocol == PROTO_ICMP) begin
      verdict_c = V_ICMP;
    end else if ((sum_data.ip_protocol == PROTO_TCP) || (sum_data.ip_protocol == PROTO_UDP)) begin
      verdict_c = V_DELIVER;
    end else begin
      reason_c = R_PROTOCOL;
    end
  end

  // refill the output register when it is free or being emptied this cycle
  assign load    = sum_valid && (!out_valid_r || out_pop);
  assign sum_pop = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= verdict_c;
      reason_r  <= reason_c;
      proto_r   <= proto_c;
      l4_r      <= l4_c;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_verdict     = verdict_r;
  assign out_drop_reason = reason_r;
  assign out_protocol    = proto_r;
  assign out_l4_length   = l4_r;

  a_reason_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (verdict_r == V_DROP)) |-> (reason_r != R_NONE))
    else $error("drop without reason");

  a_no_reason_on_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (verdict_r != V_DROP)) |-> (reason_r == R_NONE))
    else $error("reason on a passed frame");

  a_arp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (verdict_r == V_ARP)) |-> ((proto_r == 8'd0) && (l4_r == 16'd0)))
    else $error("arp verdict carries l3 fields");

  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_valid && !out_valid_r) |=> out_valid_r)
    else $error("pending summary not loaded");

endmodule

/* hdl/eth_ipv4_rx_classifier.sv */
// eth_ipv4_rx_classifier: top level, ethernet ipv4 receive header filter
// depends on eirc_pkg, eirc_front, eirc_sumq, eirc_back
//
// usage:
//   input queue: one frame byte per transfer (in_push while in_full is low), with
//   in_last_byte on the final byte and in_csum_preverified sampled on the first.
//   result queue: one verdict per frame, held on out_* while out_empty is low and
//   taken by out_pop. bytes other than the last give no result.
//   cfg: cfg_station_mac is written when cfg_valid is high (cfg_ready is always high);
//   write it only while no frame is in flight.
// timing:
//   one byte per cycle sustained while in_full is low; the front parser absorbs each
//   byte as it is taken. a verdict reaches the result ports after the last byte is
//   taken, registered first in the summary queue and then in the output register.
//   a two-entry summary queue sits between parser and verdict logic, so the
//   parser keeps taking bytes while a result waits; in_full rises only once the
//   summary queue is full and a last byte would have nowhere to go.
// reset: rst_n (synchronous) clears frame state, empties both queues and sets the
//   station address to zero. a stalled result queue back-pressures bytes through
//   in_full once the summary queue fills.
module eth_ipv4_rx_classifier import eirc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  input  logic        in_csum_preverified,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_verdict,
  output logic [2:0]  out_drop_reason,
  output logic [7:0]  out_protocol,
  output logic [15:0] out_l4_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_station_mac
);

  logic [47:0] station_mac_r, station_mac_nxt;
  logic        byte_valid;
  logic        sum_push;
  frame_sum_t  sum_in;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  frame_sum_t  q_head;

  assign cfg_ready       = 1'b1;
  assign station_mac_nxt = (cfg_valid && cfg_ready) ? cfg_station_mac : station_mac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_mac_r <= '0;
    end else begin
      station_mac_r <= station_mac_nxt;
    end
  end

  assign in_full    = q_full;
  assign byte_valid = in_push && !in_full;

  eirc_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_valid       (byte_valid),
    .frame_byte       (in_frame_byte),
    .last_byte        (in_last_byte),
    .csum_preverified (in_csum_preverified),
    .station_mac      (station_mac_r),
    .sum_push         (sum_push),
    .sum_data         (sum_in)
  );

  eirc_sumq #(
    .DEPTH (SUMQ_DEPTH)
  ) u_sumq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (sum_push),
    .push_data (sum_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  eirc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .sum_valid       (q_valid),
    .sum_data        (q_head),
    .sum_pop         (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_verdict     (out_verdict),
    .out_drop_reason (out_drop_reason),
    .out_protocol    (out_protocol),
    .out_l4_length   (out_l4_length)
  );

endmodule
